@@ rtl/dynamic_priority_scheduler_assert.svh @@
// Assertion macros shared by the scheduler RTL.
// Needs nothing else; included by files that carry concurrent assertions.
`ifndef DYNAMIC_PRIORITY_SCHEDULER_ASSERT_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define DPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is held
`define DPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed: next-cycle rule");

`endif

@@ rtl/dps_pkg.sv @@
// Shared types and constants of the dynamic priority scheduler.
// No dependencies; used by dps_ctrl, dps_dp and the top level.
`timescale 1ns / 1ps

package dps_pkg;

  // Default slot count
  localparam int NUM_PROCS_DEF = 4;

  // Field widths
  localparam int FUNC_W   = 1;
  localparam int SLOT_W   = 2;
  localparam int TIME_W   = 8;
  localparam int PRIO_W   = 12;
  localparam int BASE_W   = 8;
  localparam int DECAY_W  = 4;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 1'b1;

  localparam logic [BASE_W-1:0]  BASE_RST  = 8'd50;
  localparam logic [DECAY_W-1:0] DECAY_RST = 4'd3;

  // Item kinds
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_TICK = 1'b1;

  // Priority saturation floor
  localparam logic signed [PRIO_W:0] PRIO_MIN = -13'sd2048;
  localparam logic [TIME_W-1:0] USED_MAX = 8'd255;

  // One slot of the process table
  typedef struct packed {
    logic [TIME_W-1:0]        rem;
    logic signed [PRIO_W-1:0] prio;
    logic [TIME_W-1:0]        used;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan_clear;
    logic scan_rd;
    logic update;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_func;
    logic scan_last;
    logic out_free;
  } status_t;

endpackage

@@ rtl/dps_ctrl.sv @@
// Sequencer of the scheduler: accepts words and steps load and tick work.
// Depends on dps_pkg.
`timescale 1ns / 1ps

module dps_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  dps_pkg::status_t status,
  output dps_pkg::cmd_t    cmd
);

  dps_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      dps_pkg::ST_IDLE: begin
        // Take no word while reset is held
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          if (status.in_func == dps_pkg::FUNC_TICK) begin
            cmd.scan_clear = 1'b1;
            state_nxt      = dps_pkg::ST_SCAN;
          end else begin
            cmd.load  = 1'b1;
            state_nxt = dps_pkg::ST_FINISH;
          end
        end
      end
      dps_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (status.scan_last) begin
          state_nxt = dps_pkg::ST_DRAIN;
        end
      end
      dps_pkg::ST_DRAIN: begin
        state_nxt = dps_pkg::ST_UPDATE;
      end
      dps_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = dps_pkg::ST_FINISH;
      end
      dps_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = dps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/dps_dp.sv @@
// Datapath of the scheduler: slot table memory, scan compare, update and
// output register. Depends on dps_pkg; driven by dps_ctrl commands.
`timescale 1ns / 1ps

module dps_dp #(
  parameter int NUM_PROCS = dps_pkg::NUM_PROCS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [0:0]                       in_tuser,
  input  logic [dps_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  dps_pkg::cmd_t                    cmd,
  output dps_pkg::status_t                 status,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [0:0]                       out_tuser
);

  localparam int IDX_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;

  // Configuration registers
  logic [dps_pkg::BASE_W-1:0]  base_r;
  logic [dps_pkg::DECAY_W-1:0] decay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= dps_pkg::BASE_RST;
      decay_r <= dps_pkg::DECAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dps_pkg::REG_BASE:  base_r  <= cfg_wdata;
        dps_pkg::REG_DECAY: decay_r <= cfg_wdata[dps_pkg::DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input word
  logic [dps_pkg::SLOT_W-1:0] in_slot;
  logic [dps_pkg::TIME_W-1:0] in_need;
  assign in_slot = in_tdata[dps_pkg::SLOT_W-1:0];
  assign in_need = in_tdata[dps_pkg::SLOT_W +: dps_pkg::TIME_W];

  logic [IDX_W+1:0] slot_ext;
  logic [IDX_W-1:0] ld_addr;
  logic             ld_ok;
  logic signed [dps_pkg::PRIO_W-1:0] ld_prio;
  assign slot_ext = (IDX_W+2)'(in_slot);
  assign ld_addr  = slot_ext[IDX_W-1:0];
  assign ld_ok    = int'(in_slot) < NUM_PROCS;
  assign ld_prio  = $signed({4'b0, base_r}) - $signed({4'b0, in_need});

  // Slot table and its per-entry valid and busy flags
  dps_pkg::entry_t mem [NUM_PROCS];
  logic [NUM_PROCS-1:0] valid_r;
  logic [NUM_PROCS-1:0] busy_r;

  // Scan state
  logic [IDX_W-1:0] cnt_r;
  logic             rd_pend_r;
  logic             rd_valid_r;
  logic [IDX_W-1:0] rd_idx_r;
  dps_pkg::entry_t  rd_q;

  logic                              best_valid_r;
  logic [IDX_W-1:0]                  best_idx_r;
  logic signed [dps_pkg::PRIO_W-1:0] best_prio_r;
  logic [dps_pkg::TIME_W-1:0]        best_rem_r;
  logic [dps_pkg::TIME_W-1:0]        best_used_r;
  logic                              is_tick_r;

  // Running slot's new values
  logic signed [dps_pkg::PRIO_W:0]   dec_prio;
  logic signed [dps_pkg::PRIO_W-1:0] new_prio;
  logic [dps_pkg::TIME_W-1:0]        new_rem;
  logic [dps_pkg::TIME_W-1:0]        new_used;

  always_comb begin
    dec_prio = $signed({best_prio_r[dps_pkg::PRIO_W-1], best_prio_r})
             - $signed({9'b0, decay_r});
    if (dec_prio < dps_pkg::PRIO_MIN) begin
      new_prio = dps_pkg::PRIO_MIN[dps_pkg::PRIO_W-1:0];
    end else begin
      new_prio = dec_prio[dps_pkg::PRIO_W-1:0];
    end
    new_rem  = best_rem_r - 8'd1;
    new_used = (best_used_r == dps_pkg::USED_MAX) ? best_used_r : best_used_r + 8'd1;
  end

  // Memory write port: load or update
  logic            wr_en;
  logic [IDX_W-1:0] wr_addr;
  dps_pkg::entry_t wr_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ld_addr;
    wr_data = '{rem: in_need, prio: ld_prio, used: '0};
    if (cmd.load && ld_ok) begin
      wr_en = 1'b1;
    end else if (cmd.update && best_valid_r) begin
      wr_en   = 1'b1;
      wr_addr = best_idx_r;
      wr_data = '{rem: new_rem, prio: new_prio, used: new_used};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port for the scan
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_q <= mem[cnt_r];
    end
  end

  // Valid and busy flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      busy_r  <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
      busy_r[wr_addr]  <= (wr_data.rem != '0);
    end
  end

  // Scan counter and read pipeline flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.scan_rd;
      if (cmd.scan_clear) begin
        cnt_r <= '0;
      end else if (cmd.scan_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_valid_r <= valid_r[cnt_r];
      rd_idx_r   <= cnt_r;
    end
  end

  // Keep the best live slot; a strict compare leaves ties with the lower slot
  logic cand_take;
  assign cand_take = rd_pend_r && rd_valid_r && (rd_q.rem != '0)
                  && (!best_valid_r || ($signed(rd_q.prio) > best_prio_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
      is_tick_r    <= 1'b0;
    end else begin
      if (cmd.scan_clear) begin
        best_valid_r <= 1'b0;
        is_tick_r    <= 1'b1;
      end else if (cmd.load) begin
        is_tick_r <= 1'b0;
      end else if (cand_take) begin
        best_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cand_take) begin
      best_idx_r  <= rd_idx_r;
      best_prio_r <= $signed(rd_q.prio);
      best_rem_r  <= rd_q.rem;
      best_used_r <= rd_q.used;
    end else if (cmd.update) begin
      best_rem_r  <= new_rem;
      best_used_r <= new_used;
    end
  end

  // Output register
  logic             out_valid_r;
  logic             ran;
  logic [IDX_W+1:0] best_ext;
  logic [dps_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                            out_ran_r;

  assign ran      = is_tick_r && best_valid_r;
  assign best_ext = (IDX_W+2)'(best_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_ran_r <= ran;
      if (ran) begin
        out_data_r <= {5'b0, ~|busy_r, best_used_r, best_rem_r, best_ext[1:0]};
      end else begin
        out_data_r <= {5'b0, ~|busy_r, 18'b0};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ran_r;

  // Status back to the controller
  assign status.in_func   = in_tuser[0];
  assign status.scan_last = (cnt_r == IDX_W'(NUM_PROCS - 1));
  assign status.out_free  = !out_valid_r || out_tready;

endmodule

@@ rtl/dynamic_priority_scheduler.sv @@
// Top level of the dynamic priority scheduler: controller plus datapath.
// Depends on dps_pkg, dps_ctrl, dps_dp and the assertion macro header.
//
//   channel  | direction | handshake            | contents
//   ---------+-----------+----------------------+------------------------------
//   in_      | slave     | in_tvalid/in_tready  | tuser func, tdata slot, need
//   out_     | master    | out_tvalid/out_tready| tuser ran, tdata slot..done
//   cfg_     | write     | cfg_we               | cfg_index, cfg_wdata
//
// A load is accepted, then its result is registered in the output step.
// A tick scans the table, reading one table slot per cycle, then runs drain,
// update and output steps; the output step waits until the output is free.
// Reset clears the valid bits of the slot table directly; no clearing pass.
// A stalled result holds in the output register; the next word is taken while
// it waits, and the block only stops at its own output step.
`timescale 1ns / 1ps
`include "dynamic_priority_scheduler_assert.svh"

module dynamic_priority_scheduler #(
  parameter int NUM_PROCS = dps_pkg::NUM_PROCS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dps_pkg::IN_TDATA_W-1:0]  in_tdata,   // slot[1:0], need_time[9:2]
  input  logic [0:0]                      in_tuser,   // func[0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dps_pkg::OUT_TDATA_W-1:0] out_tdata,  // ran_slot[1:0], need_left[9:2],
                                                      // used_time[17:10], all_done[18]
  output logic [0:0]                      out_tuser   // ran[0]
);

  dps_pkg::cmd_t    cmd;
  dps_pkg::status_t status;

  dps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  dps_dp #(
    .NUM_PROCS (NUM_PROCS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Checks
  `DPS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `DPS_ASSERT_SAME(a_finish_when_free, clk, rst_n, cmd.finish, status.out_free)
  `DPS_ASSERT_SAME(a_idle_result_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata[17:0] == 18'b0)
  `DPS_ASSERT_SAME(a_done_means_empty, clk, rst_n, out_tvalid && out_tuser[0] && out_tdata[18], out_tdata[9:2] == 8'b0)

endmodule
